// File: sv/dq_pkg.sv
// Shared types and constants for the bounded deque.
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in the request kind field
    typedef enum logic [1:0] {
        OP_PUSH_LEFT  = 2'd0,
        OP_PUSH_RIGHT = 2'd1,
        OP_POP_LEFT   = 2'd2,
        OP_POP_RIGHT  = 2'd3
    } op_t;

    // Response status codes
    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_FULL   = 2'd1,
        ST_POPPED = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // Side codes
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    // Control broadcast to a whole chain of cells
    typedef struct packed {
        logic shift_up;    // every cell takes its lower neighbor
        logic shift_down;  // every cell takes its upper neighbor
        logic load_end;    // the cell entering at the open end loads new data
        logic write_en;    // one addressed cell loads new data in place
    } chain_ctrl_t;

    // Control seen by one cell
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load_end;
        logic write_hit;
    } cell_ctrl_t;

endpackage

// File: sv/dq_if.sv
// Channel interfaces: request, response and capacity write.
`timescale 1ns / 1ps

interface dq_req_if import dq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, kind, push_value, input ready);
    modport sink   (input valid, kind, push_value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic                     side;
    logic signed [DATA_W-1:0] result_value;

    modport source (output valid, status, side, result_value, input ready);
    modport sink   (input valid, status, side, result_value, output ready);
endinterface

interface dq_cfg_if import dq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

// File: sv/bounded_deque_core.sv
// Bounded deque top level: two cell chains, counter, capacity and response register.
// A response is registered in the cycle after its request transaction.
// Throughput: one transaction per cycle; the response register may be refilled in the
//   cycle it drains, so only a stalled response consumer holds off requests.
// Both chains keep the same entries: one packed at the low end, one at the high end,
//   so both deque ends are always read from fixed cells.
// Reset (async, active low): empty, capacity 16, no response pending; cells are not cleared.
`timescale 1ns / 1ps

module bounded_deque_core
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    dq_req_if.sink    req,
    dq_rsp_if.source  rsp,
    dq_cfg_if.sink    cfg
);

    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic              rsp_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic              side_reg;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    logic              fire;
    op_t               op;
    logic              full;
    logic              empty;
    chain_ctrl_t       lo_ctrl;
    chain_ctrl_t       hi_ctrl;
    logic [IW-1:0]     lo_widx;
    logic [IW-1:0]     hi_widx;
    logic [DATA_W-1:0] lo_first;
    logic [DATA_W-1:0] lo_last;
    logic [DATA_W-1:0] hi_first;
    logic [DATA_W-1:0] hi_last;

    assign fire      = req.valid && req.ready;
    assign op        = op_t'(req.kind);
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // Full when count reaches the capacity register or the physical depth
    assign full  = (CMP_W'(count_reg) >= CMP_W'(capacity_reg)) || (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Chain control, counter and response next values
    always_comb
    begin
        lo_ctrl     = '0;
        hi_ctrl     = '0;
        lo_widx     = count_reg[IW-1:0];
        hi_widx     = IW'(DEPTH - 1) - count_reg[IW-1:0];
        count_next  = count_reg;
        status_next = status_reg;
        value_next  = value_reg;
        if (fire)
        begin
            case (op)
                OP_PUSH_LEFT, OP_PUSH_RIGHT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                        value_next  = '0;
                    end
                    else
                    begin
                        status_next = ST_PUSHED;
                        value_next  = req.push_value;
                        count_next  = count_reg + CW'(1);
                        if (op == OP_PUSH_LEFT)
                        begin
                            lo_ctrl.shift_up   = 1'b1;
                            lo_ctrl.load_end   = 1'b1;
                            hi_ctrl.write_en   = 1'b1;
                        end
                        else
                        begin
                            lo_ctrl.write_en   = 1'b1;
                            hi_ctrl.shift_down = 1'b1;
                            hi_ctrl.load_end   = 1'b1;
                        end
                    end
                end
                OP_POP_LEFT, OP_POP_RIGHT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                        value_next  = '0;
                    end
                    else
                    begin
                        status_next = ST_POPPED;
                        count_next  = count_reg - CW'(1);
                        if (op == OP_POP_LEFT)
                        begin
                            value_next         = lo_first;
                            lo_ctrl.shift_down = 1'b1;
                        end
                        else
                        begin
                            value_next         = hi_last;
                            hi_ctrl.shift_up   = 1'b1;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_EMPTY;
                    value_next  = '0;
                end
            endcase
        end
    end

    // Chain packed toward cell 0 (left end at cell 0)
    dq_chain #(
        .DEPTH (DEPTH)
    ) u_lo_chain (
        .clk        (clk),
        .ctrl       (lo_ctrl),
        .write_idx  (lo_widx),
        .new_data   (req.push_value),
        .first_data (lo_first),
        .last_data  (lo_last)
    );

    // Chain packed toward the top cell (right end at the top cell)
    dq_chain #(
        .DEPTH (DEPTH)
    ) u_hi_chain (
        .clk        (clk),
        .ctrl       (hi_ctrl),
        .write_idx  (hi_widx),
        .new_data   (req.push_value),
        .first_data (hi_first),
        .last_data  (hi_last)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            capacity_reg  <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg.valid && cfg.ready)
            begin
                capacity_reg <= cfg.capacity;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        if (fire)
        begin
            side_reg <= req.kind[0];
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.side         = side_reg;
    assign rsp.result_value = value_reg;

`ifndef SYNTHESIS
    // Entry count never passes the physical depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // Every request transaction yields a pending response next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp.valid)
        else $error("response missing after request");

    // Counter advances on each push that is not refused as full
    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (op == OP_PUSH_LEFT || op == OP_PUSH_RIGHT) && !full
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("count not advanced on push");

    // Zero capacity refuses every push
    a_zero_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (capacity_reg == '0) && (op == OP_PUSH_LEFT || op == OP_PUSH_RIGHT)
        |=> status_reg == ST_FULL)
        else $error("push accepted with zero capacity");

    // At physical depth both chains line up cell for cell
    a_chains_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(DEPTH)) |-> (lo_first == hi_first) && (lo_last == hi_last))
        else $error("chains disagree when full");
`endif

endmodule

// File: sv/dq_cell.sv
// One storage cell of a shifting chain: holds one entry.
`timescale 1ns / 1ps

module dq_cell
    import dq_pkg::*;
#(
    parameter bit FIRST = 1'b0,
    parameter bit LAST  = 1'b0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] lo_data,
    input  logic [DATA_W-1:0] hi_data,
    input  logic [DATA_W-1:0] new_data,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Select source: in-place write, shift from a neighbor, new data loaded at the end, or hold
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.write_hit)
        begin
            data_next = new_data;
        end
        else if (ctrl.shift_up)
        begin
            if (FIRST)
            begin
                if (ctrl.load_end)
                begin
                    data_next = new_data;
                end
            end
            else
            begin
                data_next = lo_data;
            end
        end
        else if (ctrl.shift_down)
        begin
            if (LAST)
            begin
                if (ctrl.load_end)
                begin
                    data_next = new_data;
                end
            end
            else
            begin
                data_next = hi_data;
            end
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: sv/dq_chain.sv
// Row of deque cells with neighbor shifting and one addressed write.
`timescale 1ns / 1ps

module dq_chain
    import dq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  chain_ctrl_t       ctrl,
    input  logic [IW-1:0]     write_idx,
    input  logic [DATA_W-1:0] new_data,
    output logic [DATA_W-1:0] first_data,
    output logic [DATA_W-1:0] last_data
);

    logic [DATA_W-1:0] cell_data [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_ctrl_t        cc;
            logic [DATA_W-1:0] lo;
            logic [DATA_W-1:0] hi;

            // Local decode of the broadcast control
            assign cc.shift_up   = ctrl.shift_up;
            assign cc.shift_down = ctrl.shift_down;
            assign cc.load_end   = ctrl.load_end;
            assign cc.write_hit  = ctrl.write_en && (write_idx == IW'(i));

            if (i == 0)
            begin : g_lo_end
                assign lo = cell_data[i];
            end
            else
            begin : g_lo_mid
                assign lo = cell_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_hi_end
                assign hi = cell_data[i];
            end
            else
            begin : g_hi_mid
                assign hi = cell_data[i+1];
            end

            dq_cell #(
                .FIRST (i == 0),
                .LAST  (i == DEPTH - 1)
            ) u_cell (
                .clk      (clk),
                .ctrl     (cc),
                .lo_data  (lo),
                .hi_data  (hi),
                .new_data (new_data),
                .data     (cell_data[i])
            );
        end
    endgenerate

    assign first_data = cell_data[0];
    assign last_data  = cell_data[DEPTH-1];

endmodule
